>>> src/oahs_pkg.sv
// shared types and codes for the open-address hash set
package oahs_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int KEY_W     = 32;
  localparam int OP_W      = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // slot marks
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_LIVE    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic       success;
    logic [5:0] slot_index;
    logic [6:0] live_count;
  } out_item_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

>>> src/oahs_front.sv
// front end: accepts items and computes the home slot by serial division
module oahs_front #(
  parameter int SLOTS = oahs_pkg::SLOTS_DEF,
  parameter int NW    = $clog2(SLOTS + 1),
  parameter int IW    = $clog2(SLOTS),
  parameter int QW    = oahs_pkg::OP_W + oahs_pkg::KEY_W + IW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  oahs_pkg::in_item_t  in_data,
  input  logic [NW-1:0]       n_eff,
  input  oahs_pkg::back_stat_t stat,
  output logic                q_push,
  output logic [QW-1:0]       q_data,
  input  logic                q_full
);
  import oahs_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [KEY_W-1:0] quo_r, quo_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [NW:0]      rem_sh;
  logic [KEY_W-1:0] mag;

  assign in_ready = (state_r == F_IDLE) && !stat.clearing;
  assign mag      = in_data.key[KEY_W-1] ? (KEY_W'(0) - in_data.key) : in_data.key;
  assign rem_sh   = {rem_r, quo_r[KEY_W-1]};
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = {op_r, key_r, rem_r[IW-1:0]};

  // restoring remainder, one key bit per cycle
  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt    = in_data.operation;
          key_nxt   = in_data.key;
          quo_nxt   = mag;
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        quo_nxt = {quo_r[KEY_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, n_eff}) begin
          rem_nxt = NW'(rem_sh - {1'b0, n_eff});
        end else begin
          rem_nxt = NW'(rem_sh);
        end
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
  end

endmodule

>>> src/oahs_fifo.sv
// two-entry queue between front and back end
module oahs_fifo #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] head
);
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> src/oahs_back.sv
// back end: probe engine over the slot memories
module oahs_back #(
  parameter int SLOTS = oahs_pkg::SLOTS_DEF,
  parameter int NW    = $clog2(SLOTS + 1),
  parameter int IW    = $clog2(SLOTS),
  parameter int QW    = oahs_pkg::OP_W + oahs_pkg::KEY_W + IW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NW-1:0]        n_eff,
  input  logic                 q_empty,
  input  logic [QW-1:0]        q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output oahs_pkg::out_item_t  out_data,
  output oahs_pkg::back_stat_t stat
);
  import oahs_pkg::*;

  localparam logic [1:0] B_CLR  = 2'd0;
  localparam logic [1:0] B_IDLE = 2'd1;
  localparam logic [1:0] B_RD   = 2'd2;
  localparam logic [1:0] B_EV   = 2'd3;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [1:0]       mark_mem [SLOTS];

  logic [1:0]       state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [NW-1:0]    probe_r, probe_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic [KEY_W-1:0] rd_key_r;
  logic [1:0]       rd_mark_r;
  logic             mark_we, key_we;
  logic [1:0]       mark_wd;
  logic             out_free, done, ok;
  logic [IW-1:0]    idx_inc;

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.clearing = (state_r == B_CLR);
  assign q_pop         = (state_r == B_IDLE) && !q_empty;
  assign idx_inc       = ({1'b0, idx_r} + 1'b1 == (IW+1)'(n_eff)) ? '0 : idx_r + 1'b1;

  // probe sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mark_we       = 1'b0;
    key_we        = 1'b0;
    mark_wd       = MARK_EMPTY;
    done          = 1'b0;
    ok            = 1'b0;
    case (state_r)
      B_CLR: begin
        mark_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if ({1'b0, idx_r} == (IW+1)'(SLOTS - 1)) begin
          idx_nxt   = '0;
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          op_nxt    = q_head[QW-1 -: OP_W];
          key_nxt   = q_head[IW +: KEY_W];
          idx_nxt   = q_head[IW-1:0];
          probe_nxt = '0;
          state_nxt = (q_head[QW-1 -: OP_W] == OP_INSERT ||
                       q_head[QW-1 -: OP_W] == OP_SEARCH ||
                       q_head[QW-1 -: OP_W] == OP_REMOVE) ? B_RD : B_EV;
        end
      end
      B_RD: begin
        state_nxt = B_EV;
      end
      B_EV: begin
        if (op_r == OP_INSERT) begin
          if (rd_mark_r != MARK_LIVE) begin
            done = 1'b1;
            ok   = 1'b1;
          end else if (rd_key_r == key_r) begin
            done = 1'b1;
          end
        end else if (op_r == OP_SEARCH || op_r == OP_REMOVE) begin
          if (rd_mark_r == MARK_EMPTY) begin
            done = 1'b1;
          end else if (rd_mark_r == MARK_LIVE && rd_key_r == key_r) begin
            done = 1'b1;
            ok   = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
        if (!done && (probe_r + 1'b1 == n_eff)) begin
          done = 1'b1;
        end
        if (!done) begin
          probe_nxt = probe_r + 1'b1;
          idx_nxt   = idx_inc;
          state_nxt = B_RD;
        end else if (out_free) begin
          // commit the update and post the result
          if (ok && op_r == OP_INSERT) begin
            mark_we   = 1'b1;
            key_we    = 1'b1;
            mark_wd   = MARK_LIVE;
            count_nxt = count_r + 1'b1;
          end else if (ok && op_r == OP_REMOVE) begin
            mark_we = 1'b1;
            mark_wd = MARK_DELETED;
            if (count_r != '0) count_nxt = count_r - 1'b1;
          end
          out_valid_nxt      = 1'b1;
          out_nxt.success    = ok;
          out_nxt.slot_index = ok ? 6'(idx_r) : 6'd0;
          out_nxt.live_count = 7'(count_nxt);
          state_nxt          = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    out_r   <= out_nxt;
  end

  // mark memory
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[idx_r] <= mark_wd;
    rd_mark_r <= mark_mem[idx_r];
  end

  // key memory
  always_ff @(posedge clk) begin
    if (key_we) key_mem[idx_r] <= key_r;
    rd_key_r <= key_mem[idx_r];
  end

endmodule

>>> src/open_address_hash_set_core.sv
// top level of the open-address hash set
//
//  channel | ports                     | payload
//  in      | in_valid / in_ready       | in_data   (operation, key)
//  out     | out_valid / out_ready     | out_data  (success, slot_index, live_count)
//  cfg     | cfg_valid / cfg_ready     | cfg_data  (table_size)
//
// front end: serial remainder of the key magnitude for the home slot, then a push to the queue
// back end: pops an item, then reads and evaluates each probed slot in turn (registered memory read)
// the front end takes a new item only once the last one is queued; the two ends overlap
// after reset a clearing pass empties the marks of every slot; no item is taken then
// a stalled result holds the back end; the front end goes on until the two-entry queue fills
module open_address_hash_set_core #(
  parameter int SLOTS = oahs_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  oahs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oahs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import oahs_pkg::*;

  localparam int NW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int QW = OP_W + KEY_W + IW;
  localparam int CW = (NW > 7) ? NW : 7;

  logic [6:0]    size_r;
  logic [CW-1:0] size_w;
  logic [NW-1:0] n_eff;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_data, q_head;
  back_stat_t    stat;

  assign cfg_ready = 1'b1;
  assign size_w    = CW'(size_r);
  assign n_eff     = (size_w == '0) ? NW'(1) :
                     (size_w > CW'(SLOTS)) ? NW'(SLOTS) : NW'(size_w);

  // table size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  oahs_front #(.SLOTS(SLOTS), .NW(NW), .IW(IW), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .n_eff(n_eff), .stat(stat), .q_push(q_push),
    .q_data(q_data), .q_full(q_full)
  );

  oahs_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  oahs_back #(.SLOTS(SLOTS), .NW(NW), .IW(IW), .QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .n_eff(n_eff), .q_empty(q_empty), .q_head(q_head),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .stat(stat)
  );

  // a failed request reports slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |-> out_data.slot_index == 6'd0)
    else $error("failed item with nonzero slot");

  // no item taken during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ready)
    else $error("item accepted while clearing");

  // nothing leaves right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // queue never pushed when full
  a_q_over: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue overflow");

endmodule
